>>> src/pic_pkg.sv
`default_nettype none

package pic_pkg;

	// Field widths
	localparam int POS_W       = 24;
	localparam int CFG_W       = 23;
	localparam int MAX_STEPS_W = 11;
	localparam int DELTA_W     = POS_W + 2;
	localparam int PROD_W      = 2 * DELTA_W;
	localparam int SUM_W       = 64;
	localparam int MEAN_W      = 48;
	localparam int TRAJ_OUT_W  = 16;
	localparam int NUM_SUMS    = 6;

	// Counter widths
	localparam int STEP_COUNT_BITS = 11;
	localparam int TRAJ_COUNT_BITS = 16;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// APB
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;

	// Register reset values
	localparam logic [CFG_W-1:0]       PERIOD_A_RST  = 23'd823550;
	localparam logic [CFG_W-1:0]       PERIOD_C_RST  = 23'd274517;
	localparam logic [CFG_W-1:0]       JUMP_A_RST    = 23'd196608;
	localparam logic [CFG_W-1:0]       JUMP_C_RST    = 23'd131072;
	localparam logic [MAX_STEPS_W-1:0] MAX_STEPS_RST = 11'd1500;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_PERIOD_A  = 3'd0;
	localparam logic [2:0] REG_PERIOD_C  = 3'd1;
	localparam logic [2:0] REG_JUMP_A    = 3'd2;
	localparam logic [2:0] REG_JUMP_C    = 3'd3;
	localparam logic [2:0] REG_MAX_STEPS = 3'd4;

	// Action codes carried on tuser
	localparam logic [1:0] ACT_BEGIN  = 2'd0;
	localparam logic [1:0] ACT_SAMPLE = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0]       period_a;
		logic [CFG_W-1:0]       period_c;
		logic [CFG_W-1:0]       jump_a;
		logic [CFG_W-1:0]       jump_c;
		logic [MAX_STEPS_W-1:0] max_steps;
	} cfg_t;

	// Queue entry: an increment triple, or a finish marker whose trajectory
	// count rides zero-extended in the da field.
	typedef struct packed {
		logic                      fin;
		logic signed [DELTA_W-1:0] da;
		logic signed [DELTA_W-1:0] db;
		logic signed [DELTA_W-1:0] dc;
	} q_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_START = 3'b010,
		ST_WAIT  = 3'b100
	} back_state_t;

endpackage

`default_nettype wire

>>> src/pic_fifo.sv
`default_nettype none

module pic_fifo #(
	parameter int DEPTH = pic_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  pic_pkg::q_item_t       push_item,
	input  wire logic              pop,
	output pic_pkg::q_item_t       head,
	output pic_pkg::q_stat_t       stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pic_pkg::q_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

>>> src/pic_front.sv
`default_nettype none

module pic_front #(
	parameter int STEP_COUNT_BITS = pic_pkg::STEP_COUNT_BITS,
	parameter int TRAJ_COUNT_BITS = pic_pkg::TRAJ_COUNT_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  pic_pkg::cfg_t                  cfg,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                action,
	input  wire logic [pic_pkg::POS_W-1:0] pos_a,
	input  wire logic [pic_pkg::POS_W-1:0] pos_b,
	input  wire logic [pic_pkg::POS_W-1:0] pos_c,
	input  pic_pkg::q_stat_t               q_stat,
	output logic                           q_push,
	output pic_pkg::q_item_t               q_item
);

	localparam int DW = pic_pkg::DELTA_W;
	localparam int CW = (STEP_COUNT_BITS > pic_pkg::MAX_STEPS_W) ?
		STEP_COUNT_BITS : pic_pkg::MAX_STEPS_W;

	logic signed [pic_pkg::POS_W-1:0] last_a_q, last_b_q, last_c_q;
	logic [STEP_COUNT_BITS-1:0]        step_q;
	logic [TRAJ_COUNT_BITS-1:0]        traj_q;

	logic                 accept;
	logic                 under_cap;
	logic                 take_sample;
	logic signed [DW-1:0] raw_a, raw_b, raw_c;
	logic signed [DW-1:0] da, dc;
	logic signed [DW-1:0] jmp_a, jmp_c, per_a, per_c;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// Raw increments against the previous position
	assign raw_a = DW'(signed'(pos_a)) - DW'(last_a_q);
	assign raw_b = DW'(signed'(pos_b)) - DW'(last_b_q);
	assign raw_c = DW'(signed'(pos_c)) - DW'(last_c_q);

	assign jmp_a = signed'(DW'(cfg.jump_a));
	assign jmp_c = signed'(DW'(cfg.jump_c));
	assign per_a = signed'(DW'(cfg.period_a));
	assign per_c = signed'(DW'(cfg.period_c));

	// Unwrap a and c by one box length for this increment only
	always_comb begin
		da = raw_a;
		if (raw_a > jmp_a) begin
			da = raw_a - per_a;
		end else if (raw_a < -jmp_a) begin
			da = raw_a + per_a;
		end
		dc = raw_c;
		if (raw_c > jmp_c) begin
			dc = raw_c - per_c;
		end else if (raw_c < -jmp_c) begin
			dc = raw_c + per_c;
		end
	end

	// Samples past the step limit or the counter top are dropped
	assign under_cap   = (CW'(step_q) < CW'(cfg.max_steps)) && (step_q != '1);
	assign take_sample = accept && (action == pic_pkg::ACT_SAMPLE) && under_cap;

	// Classify and push work to the back
	always_comb begin
		q_push      = 1'b0;
		q_item.fin  = 1'b0;
		q_item.da   = da;
		q_item.db   = raw_b;
		q_item.dc   = dc;
		if (take_sample) begin
			q_push = 1'b1;
		end else if (accept && (action == pic_pkg::ACT_FINISH)) begin
			q_push     = 1'b1;
			q_item.fin = 1'b1;
			q_item.da  = signed'(DW'(traj_q));
			q_item.db  = '0;
			q_item.dc  = '0;
		end
	end

	// Track trajectory state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= '0;
			last_b_q <= '0;
			last_c_q <= '0;
			step_q   <= '0;
			traj_q   <= '0;
		end else if (accept) begin
			case (action)
				pic_pkg::ACT_BEGIN: begin
					if (traj_q != '1) begin
						traj_q <= traj_q + 1'b1;
					end
					step_q   <= '0;
					last_a_q <= signed'(pos_a);
					last_b_q <= signed'(pos_b);
					last_c_q <= signed'(pos_c);
				end
				pic_pkg::ACT_SAMPLE: begin
					if (under_cap) begin
						step_q   <= step_q + 1'b1;
						last_a_q <= signed'(pos_a);
						last_b_q <= signed'(pos_b);
						last_c_q <= signed'(pos_c);
					end
				end
				pic_pkg::ACT_FINISH: begin
					step_q   <= '0;
					traj_q   <= '0;
					last_a_q <= '0;
					last_b_q <= '0;
					last_c_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/pic_div.sv
`default_nettype none

module pic_div #(
	parameter int DIVISOR_W = pic_pkg::TRAJ_COUNT_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [pic_pkg::SUM_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]      divisor,
	output logic                           done,
	output logic [pic_pkg::SUM_W-1:0]      quotient
);

	localparam int NW    = pic_pkg::SUM_W;
	localparam int CNT_W = $clog2(NW);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NW-1:0]        quo_q;
	logic [DIVISOR_W-1:0] rem_q;

	logic [DIVISOR_W:0]   shifted;
	logic [DIVISOR_W:0]   diff;
	logic                 ge;

	// One restoring step: bring down the next dividend bit
	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign ge      = (shifted >= {1'b0, divisor});

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift quotient bits in as dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> src/pic_back.sv
`default_nettype none

module pic_back #(
	parameter int TRAJ_COUNT_BITS = pic_pkg::TRAJ_COUNT_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  pic_pkg::q_item_t                      q_head,
	input  pic_pkg::q_stat_t                      q_stat,
	output logic                                  q_pop,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [pic_pkg::MEAN_W-1:0]            mean [pic_pkg::NUM_SUMS],
	output logic [pic_pkg::TRAJ_OUT_W-1:0]        trajectories
);

	localparam int SW  = pic_pkg::SUM_W;
	localparam int MW  = pic_pkg::MEAN_W;
	localparam int PW  = pic_pkg::PROD_W;
	localparam int NS  = pic_pkg::NUM_SUMS;
	localparam int TB  = TRAJ_COUNT_BITS;
	localparam int XW  = (TB > pic_pkg::TRAJ_OUT_W) ? TB : pic_pkg::TRAJ_OUT_W;
	localparam int IW  = $clog2(NS);

	localparam logic [SW-1:0] MEAN_POS_LIM = SW'((64'd1 << (MW - 1)) - 64'd1);
	localparam logic [SW-1:0] MEAN_NEG_LIM = SW'(64'd1 << (MW - 1));
	localparam logic [MW-1:0] MEAN_HI      = {1'b0, {(MW - 1){1'b1}}};
	localparam logic [MW-1:0] MEAN_LO      = {1'b1, {(MW - 1){1'b0}}};

	pic_pkg::back_state_t state_q;

	logic                 v_s1;
	logic signed [PW-1:0] prod_s1 [NS];
	logic signed [SW-1:0] sums_q  [NS];
	logic [MW-1:0]        mean_q  [NS];
	logic [pic_pkg::TRAJ_OUT_W-1:0] traj_out_q;
	logic                 out_valid_q;
	logic [TB-1:0]        div_cnt_q;
	logic [IW-1:0]        idx_q;
	logic                 neg_q;

	logic                 pop_sample;
	logic                 pop_fin;
	logic                 div_start;
	logic                 div_done;
	logic [SW-1:0]        div_quo;
	logic signed [SW-1:0] sel_sum;
	logic [SW-1:0]        sel_mag;
	logic [SW-1:0]        quo_neg;
	logic [MW-1:0]        mean_next;
	logic                 last_idx;

	// Pick work off the queue
	assign pop_sample = (state_q == pic_pkg::ST_RUN) && !q_stat.empty && !q_head.fin;
	assign pop_fin    = (state_q == pic_pkg::ST_RUN) && !q_stat.empty && q_head.fin
		&& !v_s1 && !out_valid_q;
	assign q_pop      = pop_sample || pop_fin;

	// Form the six increment products
	always_ff @(posedge clk) begin
		if (pop_sample) begin
			prod_s1[0] <= q_head.da * q_head.da;
			prod_s1[1] <= q_head.db * q_head.db;
			prod_s1[2] <= q_head.dc * q_head.dc;
			prod_s1[3] <= q_head.da * q_head.db;
			prod_s1[4] <= q_head.da * q_head.dc;
			prod_s1[5] <= q_head.db * q_head.dc;
		end
	end

	// Divider operand: magnitude of the selected sum
	assign sel_sum = sums_q[idx_q];
	assign sel_mag = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);
	assign last_idx = (idx_q == IW'(NS - 1));

	pic_div #(
		.DIVISOR_W (TB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sel_mag),
		.divisor  (div_cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Restore sign and clamp to the mean width; zero when the count is zero
	assign quo_neg = -div_quo;
	always_comb begin
		if (div_cnt_q == '0) begin
			mean_next = '0;
		end else if (!neg_q) begin
			mean_next = (div_quo > MEAN_POS_LIM) ? MEAN_HI : div_quo[MW-1:0];
		end else begin
			mean_next = (div_quo > MEAN_NEG_LIM) ? MEAN_LO : quo_neg[MW-1:0];
		end
	end

	assign div_start = (state_q == pic_pkg::ST_START);

	// Control: accumulate, run the divisions, hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [SW:0] acc;
		if (!arst_n) begin
			state_q     <= pic_pkg::ST_RUN;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			for (int i = 0; i < NS; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			v_s1 <= pop_sample;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Saturating accumulation
			if (v_s1) begin
				for (int i = 0; i < NS; i++) begin
					acc = (SW + 1)'(sums_q[i]) + (SW + 1)'(prod_s1[i]);
					if (acc[SW] != acc[SW-1]) begin
						sums_q[i] <= acc[SW] ? {1'b1, {(SW - 1){1'b0}}}
							: {1'b0, {(SW - 1){1'b1}}};
					end else begin
						sums_q[i] <= acc[SW-1:0];
					end
				end
			end
			case (state_q)
				pic_pkg::ST_RUN: begin
					if (pop_fin) begin
						idx_q   <= '0;
						state_q <= pic_pkg::ST_START;
					end
				end
				pic_pkg::ST_START: begin
					state_q <= pic_pkg::ST_WAIT;
				end
				pic_pkg::ST_WAIT: begin
					if (div_done) begin
						if (last_idx) begin
							out_valid_q <= 1'b1;
							state_q     <= pic_pkg::ST_RUN;
							for (int i = 0; i < NS; i++) begin
								sums_q[i] <= '0;
							end
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= pic_pkg::ST_START;
						end
					end
				end
				default: begin
					state_q <= pic_pkg::ST_RUN;
				end
			endcase
		end
	end

	// Result payload and divider operands
	always_ff @(posedge clk) begin
		if (pop_fin) begin
			div_cnt_q <= q_head.da[TB-1:0];
		end
		if (div_start) begin
			neg_q <= sel_sum[SW-1];
		end
		if (div_done) begin
			mean_q[idx_q] <= mean_next;
		end
		if (div_done && last_idx) begin
			traj_out_q <= (XW'(div_cnt_q) > XW'({pic_pkg::TRAJ_OUT_W{1'b1}}))
				? {pic_pkg::TRAJ_OUT_W{1'b1}} : pic_pkg::TRAJ_OUT_W'(div_cnt_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign mean         = mean_q;
	assign trajectories = traj_out_q;

`ifndef SYNTHESIS
	a_no_acc_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != pic_pkg::ST_RUN) |-> !v_s1)
		else $error("product stage busy during division");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == pic_pkg::ST_WAIT))
		else $error("divider finished outside wait state");
	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (sums_q[0] == '0 && sums_q[5] == '0))
		else $error("sums not cleared with result");
`endif

endmodule

`default_nettype wire

>>> src/periodic_increment_covariance.sv
`default_nettype none

// Realized covariance of unwrapped 3-D position increments. Input beats carry
// an action on s_axis_tuser (begin, sample, finish) and a Q8.16 position on
// s_axis_tdata. Begin and sample beats are taken one per cycle while the
// queue is not full; samples enter a four-entry queue and are multiplied and
// accumulated one per cycle while the back end is not dividing. A finish beat
// yields one output beat with the six sums divided by the trajectory count,
// computed by the single shared radix-2 divider (one quotient bit per cycle,
// 64 bits per sum). Meanwhile the front keeps taking beats until the queue
// fills. Registers (APB, byte address 4*i): period_a, period_c, jump_a, jump_c,
// max_steps; write them only while the block is idle.
module periodic_increment_covariance #(
	parameter int STEP_COUNT_BITS = pic_pkg::STEP_COUNT_BITS,
	parameter int TRAJ_COUNT_BITS = pic_pkg::TRAJ_COUNT_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// APB configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [pic_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [pic_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pic_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	// Input stream
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [71:0]                    s_axis_tdata,  // pos_a, pos_b, pos_c
	input  wire logic [1:0]                     s_axis_tuser,  // action
	// Output stream
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// mean_aa, mean_bb, mean_cc, mean_ab, mean_ac, mean_bc, trajectories
	output logic [303:0]                        m_axis_tdata
);

	localparam int PW = pic_pkg::POS_W;
	localparam int CW = pic_pkg::CFG_W;

	pic_pkg::cfg_t    cfg_q;
	pic_pkg::q_item_t push_item;
	pic_pkg::q_item_t q_head;
	pic_pkg::q_stat_t q_stat;
	logic             q_push;
	logic             q_pop;
	logic             cfg_wr;
	logic [2:0]       reg_idx;

	logic [pic_pkg::MEAN_W-1:0]     mean [pic_pkg::NUM_SUMS];
	logic [pic_pkg::TRAJ_OUT_W-1:0] trajectories;

	// Register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_a  <= pic_pkg::PERIOD_A_RST;
			cfg_q.period_c  <= pic_pkg::PERIOD_C_RST;
			cfg_q.jump_a    <= pic_pkg::JUMP_A_RST;
			cfg_q.jump_c    <= pic_pkg::JUMP_C_RST;
			cfg_q.max_steps <= pic_pkg::MAX_STEPS_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				pic_pkg::REG_PERIOD_A:  cfg_q.period_a  <= pwdata[CW-1:0];
				pic_pkg::REG_PERIOD_C:  cfg_q.period_c  <= pwdata[CW-1:0];
				pic_pkg::REG_JUMP_A:    cfg_q.jump_a    <= pwdata[CW-1:0];
				pic_pkg::REG_JUMP_C:    cfg_q.jump_c    <= pwdata[CW-1:0];
				pic_pkg::REG_MAX_STEPS: cfg_q.max_steps <= pwdata[pic_pkg::MAX_STEPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			pic_pkg::REG_PERIOD_A:  prdata = pic_pkg::APB_DATA_W'(cfg_q.period_a);
			pic_pkg::REG_PERIOD_C:  prdata = pic_pkg::APB_DATA_W'(cfg_q.period_c);
			pic_pkg::REG_JUMP_A:    prdata = pic_pkg::APB_DATA_W'(cfg_q.jump_a);
			pic_pkg::REG_JUMP_C:    prdata = pic_pkg::APB_DATA_W'(cfg_q.jump_c);
			pic_pkg::REG_MAX_STEPS: prdata = pic_pkg::APB_DATA_W'(cfg_q.max_steps);
			default:                prdata = '0;
		endcase
	end

	pic_front #(
		.STEP_COUNT_BITS (STEP_COUNT_BITS),
		.TRAJ_COUNT_BITS (TRAJ_COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.action   (s_axis_tuser),
		.pos_a    (s_axis_tdata[PW-1:0]),
		.pos_b    (s_axis_tdata[2*PW-1:PW]),
		.pos_c    (s_axis_tdata[3*PW-1:2*PW]),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	pic_fifo #(
		.DEPTH (pic_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	pic_back #(
		.TRAJ_COUNT_BITS (TRAJ_COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_head       (q_head),
		.q_stat       (q_stat),
		.q_pop        (q_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.mean         (mean),
		.trajectories (trajectories)
	);

	assign m_axis_tdata = {trajectories, mean[5], mean[4], mean[3], mean[2], mean[1], mean[0]};

endmodule

`default_nettype wire
